### src/drpc_pkg.sv
package drpc_pkg;

   typedef enum logic [2:0] {
      MODE_NEXT  = 3'd0,
      MODE_ADD   = 3'd1,
      MODE_PURGE = 3'd2,
      MODE_SPEED = 3'd3,
      MODE_FUNC  = 3'd4,
      MODE_STEP  = 3'd5,
      MODE_ESTOP = 3'd6,
      MODE_RSVD  = 3'd7
   } mode_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_TAKEN = 2'd2;
   localparam logic [1:0] STATUS_QFULL = 2'd3;

   localparam logic [0:0] KIND_BYTE   = 1'b0;
   localparam logic [0:0] KIND_STATUS = 1'b1;

   localparam logic [7:0] BYTE_STOP      = 8'b0111_0001;
   localparam logic [7:0] BYTE_ADV_SPEED = 8'h3F;
   localparam logic [7:0] BYTE_FG1       = 8'h80;
   localparam logic [7:0] BYTE_FG2       = 8'hB0;
   localparam logic [7:0] BYTE_FG2A      = 8'hA0;
   localparam logic [7:0] BYTE_FG4       = 8'hDE;
   localparam logic [7:0] BYTE_FG5       = 8'hDF;
   localparam logic [7:0] MASK_NIBBLE    = 8'h0F;
   localparam logic [7:0] BYTE_SPEED     = 8'b0100_0000;
   localparam logic [7:0] BIT_FORWARD    = 8'b0010_0000;
   localparam logic [7:0] BYTE_IDLE      = 8'hFF;
   localparam logic [7:0] SPEED_STOPPED  = 8'h80;

   localparam logic [2:0] REPEAT_STOP    = 3'd6;
   localparam logic [2:0] REPEAT_ONCE    = 3'd1;
   localparam logic [2:0] REPEAT_FUNC    = 3'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  handle;
      logic [15:0] loco_address;
      logic [7:0]  value;
      logic [2:0]  group;
      logic [1:0]  step_mode;
   } req_type;

   typedef struct packed {
      logic [0:0] kind;
      logic [7:0] packet_byte;
      logic       last;
      logic [2:0] repeat_res;
      logic [4:0] handle_out;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [4:0]  handle;
      logic        in_range;
      logic [15:0] address;
      logic        addr_zero;
      logic [7:0]  value;
      logic [2:0]  group;
      logic        group_ok;
      logic [1:0]  step_mode;
   } cmd_type;

endpackage

### src/drpc_front.sv
module drpc_front import drpc_pkg::*; #(
   parameter int SESSIONS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd_data
);

   cmd_type    dec;
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      dec.mode      = mode_type'(req_data.mode);
      dec.handle    = req_data.handle;
      dec.in_range  = ({2'b00, req_data.handle} < 7'(SESSIONS));
      dec.address   = {req_data.loco_address[14], req_data.loco_address[14:0]};
      dec.addr_zero = (req_data.loco_address == 16'd0);
      dec.value     = req_data.value;
      dec.group     = req_data.group;
      dec.group_ok  = (req_data.group >= 3'd1) && (req_data.group <= 3'd5);
      dec.step_mode = req_data.step_mode;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

### src/drpc_back.sv
module drpc_back import drpc_pkg::*; #(
   parameter int SESSIONS      = 32,
   parameter int ONESHOT_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(SESSIONS);
   localparam int CW = $clog2(SESSIONS + 1);
   localparam int QW = $clog2(ONESHOT_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_SCAN, S_ADD_RD, S_ADD_WR, S_PURGE, S_SPEED, S_FUNC, S_STEP,
      S_ESTOP, S_OS, S_RF, S_RF_ADV, S_EMIT, S_STATUS
   } state_type;

   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  speed;
      logic [23:0] functions;
      logic [1:0]  step_mode;
   } slot_type;

   typedef struct packed {
      logic [4:0][7:0] bytes;
      logic [2:0]      len;
   } pkt_type;

   typedef struct packed {
      logic [2:0]      rep;
      logic [2:0]      cnt;
      logic [4:0][7:0] bytes;
   } os_type;

   typedef struct packed {
      logic [7:0] p0;
      logic [7:0] p1;
      logic       two;
   } payload_type;

   function automatic pkt_type assemble(input logic [15:0] a, input payload_type p);
      logic [7:0] cks;
      pkt_type    r;
      r = '0;
      if (a[14]) begin
         r.bytes[0] = a[15:8];
         r.bytes[1] = a[7:0];
         r.bytes[2] = p.p0;
         cks = a[15:8] ^ a[7:0] ^ p.p0;
         if (p.two) begin
            r.bytes[3] = p.p1;
            r.bytes[4] = cks ^ p.p1;
            r.len      = 3'd5;
         end else begin
            r.bytes[3] = cks;
            r.len      = 3'd4;
         end
      end else begin
         r.bytes[0] = a[7:0];
         r.bytes[1] = p.p0;
         cks = a[7:0] ^ p.p0;
         if (p.two) begin
            r.bytes[2] = p.p1;
            r.bytes[3] = cks ^ p.p1;
            r.len      = 3'd4;
         end else begin
            r.bytes[2] = cks;
            r.len      = 3'd3;
         end
      end
      return r;
   endfunction

   function automatic payload_type speed_payload(input logic [7:0] s, input logic [1:0] sm);
      payload_type p;
      logic [7:0]  r;
      p = '0;
      r = BYTE_SPEED | (s[7] ? BIT_FORWARD : 8'h00);
      if (sm == 2'd0) begin
         p.p0  = BYTE_ADV_SPEED;
         p.p1  = s;
         p.two = 1'b1;
      end else if (s[6:0] == 7'd1) begin
         p.p0 = r | 8'h01;
      end else if (sm == 2'd3) begin
         p.p0 = r | {4'h0, s[6:3]};
      end else begin
         p.p0 = r | {4'h0, s[6:3]} | (s[2] ? 8'h10 : 8'h00);
      end
      return p;
   endfunction

   function automatic pkt_type fixed3(input logic [7:0] b0, b1, b2);
      pkt_type r;
      r = '0;
      r.bytes[0] = b0;
      r.bytes[1] = b1;
      r.bytes[2] = b2;
      r.len      = 3'd3;
      return r;
   endfunction

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SESSIONS-1:0]  valid_ff, valid_in;
   logic [SESSIONS-1:0]  init_ff, init_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic [CW-1:0]        left_ff, left_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        free_ff, free_in;
   logic [IW-1:0]        ri_ff, ri_in;
   logic [2:0]           phase_ff, phase_in;
   logic                 idle_ff, idle_in;
   logic                 stop_ff, stop_in;
   logic [QW-1:0]        head_ff, head_in;
   logic [QW-1:0]        tail_ff, tail_in;
   logic [ONESHOT_DEPTH-1:0] osv_ff, osv_in;
   pkt_type              pkt_ff, pkt_in;
   logic [2:0]           idx_ff, idx_in;
   logic [2:0]           rep_ff, rep_in;
   logic [1:0]           st_ff, st_in;
   logic [4:0]           hout_ff, hout_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   slot_type             slot_mem [SESSIONS];
   slot_type             rd_q_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 rd_init_ff;
   os_type               os_mem [ONESHOT_DEPTH];
   os_type               os_q_ff;

   logic [IW-1:0]        slot_rd_addr;
   logic                 slot_we;
   logic [IW-1:0]        slot_wa;
   slot_type             slot_wd;
   logic                 os_we;
   logic [QW-1:0]        os_wa;
   os_type               os_wd;

   slot_type             cur;
   slot_type             upd;
   pkt_type              built;
   payload_type          pay;
   logic [IW-1:0]        new_h;
   logic [IW-1:0]        cmd_h;
   logic [IW-1:0]        ri_next;
   logic [IW-1:0]        scan_idx;
   logic                 out_free;
   logic [2:0]           os_cnt;

   assign cur      = rd_init_ff ? rd_q_ff : '0;
   assign new_h    = IW'(cmd_data.handle);
   assign cmd_h    = IW'(cmd_ff.handle);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ri_next  = (ri_ff == IW'(SESSIONS - 1)) ? '0 : ri_ff + 1'b1;
   assign scan_idx = (scan_ff < CW'(SESSIONS)) ? IW'(scan_ff) : '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      valid_in     = valid_ff;
      init_in      = init_ff;
      scan_in      = scan_ff;
      left_in      = left_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      ri_in        = ri_ff;
      phase_in     = phase_ff;
      idle_in      = idle_ff;
      stop_in      = stop_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      osv_in       = osv_ff;
      pkt_in       = pkt_ff;
      idx_in       = idx_ff;
      rep_in       = rep_ff;
      st_in        = st_ff;
      hout_in      = hout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      slot_rd_addr = ri_ff;
      slot_we      = 1'b0;
      slot_wa      = rd_idx_ff;
      slot_wd      = cur;
      os_we        = 1'b0;
      os_wa        = head_ff;
      os_wd        = '0;
      upd          = cur;
      pay          = '0;
      built        = '0;
      os_cnt       = os_q_ff.cnt;

      unique case (state_ff)
         S_IDLE: begin
            idx_in = 3'd0;
            rep_in = REPEAT_ONCE;
            st_in  = STATUS_OK;
            hout_in = 5'd0;
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               if (cmd_data.in_range) begin
                  slot_rd_addr = (cmd_data.mode == MODE_NEXT) ? ri_ff : new_h;
               end
               unique case (cmd_data.mode)
                  MODE_NEXT: begin
                     if (stop_ff) begin
                        stop_in  = 1'b0;
                        pkt_in   = fixed3(8'h00, BYTE_STOP, BYTE_STOP);
                        rep_in   = REPEAT_STOP;
                        state_in = S_EMIT;
                     end else if (idle_ff) begin
                        idle_in  = 1'b0;
                        pkt_in   = fixed3(BYTE_IDLE, 8'h00, BYTE_IDLE);
                        state_in = S_EMIT;
                     end else if (osv_ff[tail_ff]) begin
                        state_in = S_OS;
                     end else begin
                        state_in = S_RF;
                     end
                  end
                  MODE_ADD: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     if (!cmd_data.addr_zero) state_in = S_ADD_SCAN;
                  end
                  MODE_PURGE: begin
                     state_in = cmd_data.in_range ? S_PURGE : S_STATUS;
                  end
                  MODE_SPEED: begin
                     state_in = (cmd_data.in_range && valid_ff[new_h]) ? S_SPEED : S_STATUS;
                  end
                  MODE_FUNC: begin
                     state_in = (cmd_data.in_range && valid_ff[new_h] && cmd_data.group_ok) ?
                                S_FUNC : S_STATUS;
                  end
                  MODE_STEP: begin
                     state_in = (cmd_data.in_range && valid_ff[new_h]) ? S_STEP : S_STATUS;
                  end
                  MODE_ESTOP: begin
                     stop_in  = 1'b1;
                     scan_in  = '0;
                     state_in = S_ESTOP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_SCAN: begin
            slot_rd_addr = scan_idx;
            if (scan_ff != CW'(SESSIONS)) scan_in = scan_ff + 1'b1;
            if (scan_ff != '0) begin
               if (valid_ff[rd_idx_ff] && (cur.address == cmd_ff.address)) begin
                  st_in    = STATUS_TAKEN;
                  state_in = S_STATUS;
               end else begin
                  if (!valid_ff[rd_idx_ff] && !found_ff) begin
                     found_in = 1'b1;
                     free_in  = rd_idx_ff;
                  end
                  if (rd_idx_ff == IW'(SESSIONS - 1)) begin
                     if (found_in) begin
                        state_in = S_ADD_RD;
                     end else begin
                        st_in    = STATUS_FULL;
                        state_in = S_STATUS;
                     end
                  end
               end
            end
         end
         S_ADD_RD: begin
            slot_rd_addr = free_ff;
            state_in     = S_ADD_WR;
         end
         S_ADD_WR: begin
            upd.address       = cmd_ff.address;
            slot_we           = 1'b1;
            slot_wd           = upd;
            valid_in[free_ff] = 1'b1;
            init_in[free_ff]  = 1'b1;
            hout_in           = 5'(free_ff);
            state_in          = S_STATUS;
         end
         S_PURGE: begin
            upd.address     = 16'd0;
            upd.speed       = SPEED_STOPPED;
            upd.functions   = 24'd0;
            slot_we         = 1'b1;
            slot_wd         = upd;
            valid_in[cmd_h] = 1'b0;
            init_in[cmd_h]  = 1'b1;
            state_in        = S_STATUS;
         end
         S_SPEED, S_FUNC: begin
            if (state_ff == S_SPEED) begin
               upd.speed = cmd_ff.value;
               pay       = speed_payload(cmd_ff.value, cur.step_mode);
            end else begin
               case (cmd_ff.group)
                  3'd1: begin
                     upd.functions[7:0] = cmd_ff.value;
                     pay.p0 = BYTE_FG1 | {3'b000, cmd_ff.value[4:0]};
                  end
                  3'd2: begin
                     upd.functions[15:8] = cmd_ff.value;
                     pay.p0 = BYTE_FG2 | (cmd_ff.value & MASK_NIBBLE);
                  end
                  3'd3: begin
                     upd.functions[23:16] = cmd_ff.value;
                     pay.p0 = BYTE_FG2A | (cmd_ff.value & MASK_NIBBLE);
                  end
                  3'd4: begin
                     pay.p0  = BYTE_FG4;
                     pay.p1  = cmd_ff.value;
                     pay.two = 1'b1;
                  end
                  default: begin
                     pay.p0  = BYTE_FG5;
                     pay.p1  = cmd_ff.value;
                     pay.two = 1'b1;
                  end
               endcase
            end
            built   = assemble(cur.address, pay);
            slot_we = 1'b1;
            slot_wd = upd;
            if (osv_ff[head_ff]) begin
               st_in = STATUS_QFULL;
            end else begin
               os_we           = 1'b1;
               os_wd.rep       = (state_ff == S_SPEED) ? REPEAT_ONCE : REPEAT_FUNC;
               os_wd.cnt       = built.len;
               os_wd.bytes     = built.bytes;
               osv_in[head_ff] = 1'b1;
               head_in = (head_ff == QW'(ONESHOT_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            end
            state_in = S_STATUS;
         end
         S_STEP: begin
            upd.step_mode = cmd_ff.step_mode;
            slot_we       = 1'b1;
            slot_wd       = upd;
            state_in      = S_STATUS;
         end
         S_ESTOP: begin
            slot_rd_addr = scan_idx;
            if (scan_ff != CW'(SESSIONS)) scan_in = scan_ff + 1'b1;
            if (scan_ff != '0) begin
               upd.speed          = {cur.speed[7], 7'd1};
               slot_we            = 1'b1;
               slot_wd            = upd;
               init_in[rd_idx_ff] = 1'b1;
               if (rd_idx_ff == IW'(SESSIONS - 1)) state_in = S_STATUS;
            end
         end
         S_OS: begin
            if (os_cnt > 3'd5) os_cnt = 3'd5;
            if (os_cnt == 3'd0) os_cnt = 3'd1;
            pkt_in.bytes = os_q_ff.bytes;
            pkt_in.len   = os_cnt;
            if (os_q_ff.rep > 3'd1) begin
               os_we     = 1'b1;
               os_wa     = tail_ff;
               os_wd     = os_q_ff;
               os_wd.rep = os_q_ff.rep - 1'b1;
               idle_in   = 1'b1;
            end else begin
               osv_in[tail_ff] = 1'b0;
               tail_in = (tail_ff == QW'(ONESHOT_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            end
            state_in = S_EMIT;
         end
         S_RF: begin
            if (valid_ff[ri_ff]) begin
               case (phase_ff)
                  3'd0: pay.p0 = BYTE_FG1 | {3'b000, cur.functions[4:0]};
                  3'd1: pay.p0 = BYTE_FG2 | {4'h0, cur.functions[11:8]};
                  3'd2: pay.p0 = BYTE_FG2A | {4'h0, cur.functions[19:16]};
                  default: pay = speed_payload(cur.speed, cur.step_mode);
               endcase
               pkt_in = assemble(cur.address, pay);
            end else begin
               pkt_in  = fixed3(BYTE_IDLE, 8'h00, BYTE_IDLE);
               idle_in = 1'b0;
            end
            left_in  = CW'(SESSIONS);
            state_in = S_RF_ADV;
         end
         S_RF_ADV: begin
            ri_in   = ri_next;
            left_in = left_ff - 1'b1;
            if (ri_next == '0) begin
               idle_in  = 1'b1;
               phase_in = (phase_ff >= 3'd6) ? 3'd0 : phase_ff + 1'b1;
            end
            if (valid_ff[ri_next] || (left_ff == CW'(1))) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_BYTE;
               rsp_data_in.packet_byte = pkt_ff.bytes[idx_ff];
               rsp_data_in.last        = (idx_ff == pkt_ff.len - 1'b1);
               rsp_data_in.repeat_res  = rep_ff;
               rsp_data_in.handle_out  = 5'd0;
               rsp_data_in.status      = STATUS_OK;
               idx_in                  = idx_ff + 1'b1;
               if (idx_ff == pkt_ff.len - 1'b1) state_in = S_IDLE;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_STATUS;
               rsp_data_in.packet_byte = 8'h00;
               rsp_data_in.last        = 1'b1;
               rsp_data_in.repeat_res  = REPEAT_ONCE;
               rsp_data_in.handle_out  = hout_ff;
               rsp_data_in.status      = st_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         init_ff      <= '0;
         found_ff     <= 1'b0;
         ri_ff        <= '0;
         phase_ff     <= 3'd0;
         idle_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         osv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         init_ff      <= init_in;
         found_ff     <= found_in;
         ri_ff        <= ri_in;
         phase_ff     <= phase_in;
         idle_ff      <= idle_in;
         stop_ff      <= stop_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         osv_ff       <= osv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      left_ff     <= left_in;
      free_ff     <= free_in;
      pkt_ff      <= pkt_in;
      idx_ff      <= idx_in;
      rep_ff      <= rep_in;
      st_ff       <= st_in;
      hout_ff     <= hout_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      rd_q_ff    <= slot_mem[slot_rd_addr];
      rd_idx_ff  <= slot_rd_addr;
      rd_init_ff <= init_ff[slot_rd_addr];
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
   end

   always_ff @(posedge clock) begin
      os_q_ff <= os_mem[tail_ff];
      if (os_we) begin
         os_mem[os_wa] <= os_wd;
      end
   end

endmodule

### src/dcc_refresh_packet_scheduler_core.sv
// Add session and emergency stop both scan the session table one entry per cycle. A next
// packet request waits while a refresh steps to the next valid session, then gives its packet
// one byte a cycle while the output accepts them; output back-pressure holds the bytes.
// Requests are carried out one at a time; a two-entry queue holds requests while busy.
// Reset is synchronous; it clears queue, flags, pointers and valid bits, and table entries
// never written read as zero through per-entry written bits.
module dcc_refresh_packet_scheduler_core import drpc_pkg::*; #(
   parameter int SESSIONS      = 32,
   parameter int ONESHOT_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   drpc_front #(
      .SESSIONS(SESSIONS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data)
   );

   drpc_back #(
      .SESSIONS     (SESSIONS),
      .ONESHOT_DEPTH(ONESHOT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

### verif/tb_dcc_refresh_packet_scheduler_core.sv
`timescale 1ns / 1ps

module tb_dcc_refresh_packet_scheduler_core;
   import drpc_pkg::*;

   class refresh_scoreboard;
      bit        valid[32];
      bit [15:0] addr[32];
      bit [7:0]  speed[32];
      bit [23:0] funcs[32];
      bit [1:0]  steps[32];
      bit [7:0]  qbytes[16][6];
      bit        qvalid[16];
      int        qcount[16];
      int        qrep[16];
      int        head, tail, rindex, rphase;
      bit        idle_pend, stop_pend;
      bit [7:0]  pkt[6];
      int        len;
      rsp_type   pending[$];
      int        mismatches, checked;

      function void push(bit [0:0] kind, bit [7:0] b, bit lst, bit [2:0] rep,
                         bit [4:0] h, bit [1:0] st);
         rsp_type e;
         e.kind = kind;
         e.packet_byte = b;
         e.last = lst;
         e.repeat_res = rep;
         e.handle_out = h;
         e.status = st;
         pending.push_back(e);
      endfunction

      function void push_status(bit [4:0] h, bit [1:0] st);
         push(KIND_STATUS, 8'h00, 1'b1, REPEAT_ONCE, h, st);
      endfunction

      function void emit(bit [2:0] rep);
         for (int k = 0; k < len; k++) begin
            push(KIND_BYTE, pkt[k], k == len - 1, rep, 5'd0, STATUS_OK);
         end
      endfunction

      function void emit_idle();
         pkt[0] = BYTE_IDLE;
         pkt[1] = 8'h00;
         pkt[2] = BYTE_IDLE;
         len = 3;
         idle_pend = 0;
         emit(REPEAT_ONCE);
      endfunction

      function void put_addr(int h);
         if (addr[h][14]) begin
            pkt[0] = addr[h][15:8];
            pkt[1] = addr[h][7:0];
            len = 2;
         end else begin
            pkt[0] = addr[h][7:0];
            len = 1;
         end
      endfunction

      function bit [7:0] coarse_speed(bit [7:0] s, bit fine);
         bit [7:0] r;
         r = BYTE_SPEED;
         if (s[7]) r |= BIT_FORWARD;
         if (s[6:0] == 7'd1) return r | 8'h01;
         r |= {1'b0, s[6:0]} >> 3;
         if (fine && s[2]) r |= 8'h10;
         return r;
      endfunction

      function void put_speed(int h);
         case (steps[h])
            2'd0: begin
               pkt[len++] = BYTE_ADV_SPEED;
               pkt[len++] = speed[h];
            end
            2'd3: pkt[len++] = coarse_speed(speed[h], 1'b0);
            default: pkt[len++] = coarse_speed(speed[h], 1'b1);
         endcase
      endfunction

      function void seal();
         bit [7:0] c;
         c = 0;
         for (int i = 0; i < len; i++) c ^= pkt[i];
         pkt[len++] = c;
      endfunction

      function bit [1:0] enqueue(int rep);
         if (qvalid[head]) return STATUS_QFULL;
         for (int i = 0; i < 6; i++) qbytes[head][i] = (i < len) ? pkt[i] : 8'h00;
         qvalid[head] = 1;
         qcount[head] = len;
         qrep[head] = rep;
         head = (head + 1) % 16;
         return STATUS_OK;
      endfunction

      function void send_oneshot();
         int cnt;
         cnt = qcount[tail];
         if (cnt > 5) cnt = 5;
         if (cnt == 0) cnt = 1;
         for (int i = 0; i < cnt; i++) pkt[i] = qbytes[tail][i];
         len = cnt;
         emit(REPEAT_ONCE);
         if (qrep[tail] > 1) begin
            qrep[tail]--;
            idle_pend = 1;
         end else begin
            qvalid[tail] = 0;
            tail = (tail + 1) % 16;
         end
      endfunction

      function void send_refresh();
         int h;
         h = rindex;
         if (valid[h]) begin
            put_addr(h);
            case (rphase)
               0: pkt[len++] = BYTE_FG1 | {3'b0, funcs[h][4:0]};
               1: pkt[len++] = BYTE_FG2 | (funcs[h][15:8] & MASK_NIBBLE);
               2: pkt[len++] = BYTE_FG2A | (funcs[h][23:16] & MASK_NIBBLE);
               default: put_speed(h);
            endcase
            seal();
            emit(REPEAT_ONCE);
         end else begin
            emit_idle();
         end
         for (int left = 32; left > 0; left--) begin
            rindex++;
            if (rindex >= 32) begin
               rindex = 0;
               idle_pend = 1;
               rphase = (rphase >= 6) ? 0 : rphase + 1;
            end
            if (valid[rindex]) break;
         end
      endfunction

      function void next_packet();
         if (stop_pend) begin
            stop_pend = 0;
            pkt[0] = 8'h00;
            pkt[1] = BYTE_STOP;
            pkt[2] = BYTE_STOP;
            len = 3;
            emit(REPEAT_STOP);
         end else if (idle_pend) begin
            emit_idle();
         end else if (qvalid[tail]) begin
            send_oneshot();
         end else begin
            send_refresh();
         end
      endfunction

      function void add_session(bit [15:0] a_in);
         bit [15:0] a;
         int        free_h;
         if (a_in == 0) return;
         a = {a_in[14], a_in[14:0]};
         free_h = 32;
         for (int i = 0; i < 32; i++) begin
            if (valid[i]) begin
               if (addr[i] == a) begin
                  push_status(5'd0, STATUS_TAKEN);
                  return;
               end
            end else if (free_h == 32) begin
               free_h = i;
            end
         end
         if (free_h == 32) begin
            push_status(5'd0, STATUS_FULL);
            return;
         end
         addr[free_h] = a;
         valid[free_h] = 1;
         push_status(5'(free_h), STATUS_OK);
      endfunction

      function void note(req_type r);
         int h;
         h = r.handle;
         case (mode_type'(r.mode))
            MODE_NEXT: next_packet();
            MODE_ADD: add_session(r.loco_address);
            MODE_PURGE: begin
               valid[h] = 0;
               addr[h] = 0;
               speed[h] = SPEED_STOPPED;
               funcs[h] = 0;
               push_status(5'd0, STATUS_OK);
            end
            MODE_SPEED: begin
               if (!valid[h]) begin
                  push_status(5'd0, STATUS_OK);
               end else begin
                  speed[h] = r.value;
                  put_addr(h);
                  put_speed(h);
                  seal();
                  push_status(5'd0, enqueue(1));
               end
            end
            MODE_FUNC: begin
               if (!valid[h] || r.group < 1 || r.group > 5) begin
                  push_status(5'd0, STATUS_OK);
               end else begin
                  if (r.group == 1) funcs[h][7:0] = r.value;
                  if (r.group == 2) funcs[h][15:8] = r.value;
                  if (r.group == 3) funcs[h][23:16] = r.value;
                  put_addr(h);
                  case (r.group)
                     3'd1: pkt[len++] = BYTE_FG1 | {3'b0, r.value[4:0]};
                     3'd2: pkt[len++] = BYTE_FG2 | (r.value & MASK_NIBBLE);
                     3'd3: pkt[len++] = BYTE_FG2A | (r.value & MASK_NIBBLE);
                     3'd4: begin
                        pkt[len++] = BYTE_FG4;
                        pkt[len++] = r.value;
                     end
                     default: begin
                        pkt[len++] = BYTE_FG5;
                        pkt[len++] = r.value;
                     end
                  endcase
                  seal();
                  push_status(5'd0, enqueue(2));
               end
            end
            MODE_STEP: begin
               if (valid[h]) steps[h] = r.step_mode;
               push_status(5'd0, STATUS_OK);
            end
            MODE_ESTOP: begin
               stop_pend = 1;
               for (int i = 0; i < 32; i++) speed[i] = (speed[i] & 8'h80) | 8'h01;
               push_status(5'd0, STATUS_OK);
            end
            default: ;
         endcase
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.kind !== e.kind || got.packet_byte !== e.packet_byte ||
             got.last !== e.last || got.repeat_res !== e.repeat_res ||
             got.handle_out !== e.handle_out || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
         end
      endfunction

      function int any_valid();
         for (int i = 0; i < 32; i++) if (valid[i]) return i;
         return -1;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   refresh_scoreboard sb = new();
   int  items;
   int  hold_cycles;
   int  stall_cycles;
   int  quiet_cycles;
   bit  quiet;

   dcc_refresh_packet_scheduler_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_ready = 0;
      stall_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready = 0;
         end else if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cycles = $urandom_range(1, 16) - 1;
            rsp_ready = 0;
         end else begin
            rsp_ready = 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= 3000) begin
               $display("Timeout with %0d results outstanding.", sb.pending.size());
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   task automatic issue(input req_type r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_data = r;
      req_valid = 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(r);
      if (!(r.mode == MODE_RSVD || (r.mode == MODE_ADD && r.loco_address == 0))) items++;
   endtask

   function automatic req_type make_req(mode_type m, int h, bit [15:0] a, bit [7:0] v,
                                        int g, int s);
      req_type r;
      r.mode = m;
      r.handle = 5'(h);
      r.loco_address = a;
      r.value = v;
      r.group = 3'(g);
      r.step_mode = 2'(s);
      return r;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      w;
      r = req_type'({$urandom, $urandom});
      w = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) r.handle = 5'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) begin
         r.loco_address = {2'($urandom_range(0, 3)), 14'($urandom_range(1, 12))};
      end
      if (w < 45) r.mode = MODE_NEXT;
      else if (w < 57) r.mode = MODE_ADD;
      else if (w < 63) r.mode = MODE_PURGE;
      else if (w < 76) r.mode = MODE_SPEED;
      else if (w < 88) r.mode = MODE_FUNC;
      else if (w < 94) r.mode = MODE_STEP;
      else if (w < 96) r.mode = MODE_ESTOP;
      else if (w < 98) r.mode = MODE_RSVD;
      else begin
         r.mode = MODE_ADD;
         r.loco_address = 16'h0000;
      end
      return r;
   endfunction

   initial begin
      int h;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      hold_cycles = 0;
      quiet = 0;
      items = 0;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      issue(make_req(MODE_ADD, 0, 16'h0003, 8'h00, 0, 0));
      issue(make_req(MODE_ADD, 0, 16'hC0FF, 8'h00, 0, 0));
      issue(make_req(MODE_ADD, 0, 16'h40FF, 8'h00, 0, 0));
      issue(make_req(MODE_ADD, 0, 16'h0000, 8'h00, 0, 0));
      issue(make_req(MODE_RSVD, 31, 16'hFFFF, 8'hFF, 7, 3));
      issue(make_req(MODE_STEP, 0, 16'h0000, 8'h00, 0, 3));
      issue(make_req(MODE_SPEED, 0, 16'h0000, 8'h81, 0, 0));
      issue(make_req(MODE_SPEED, 1, 16'h0000, 8'hFF, 0, 0));
      issue(make_req(MODE_STEP, 1, 16'h0000, 8'h00, 0, 2));
      issue(make_req(MODE_SPEED, 1, 16'h0000, 8'h7C, 0, 0));
      for (int g = 0; g < 8; g++) begin
         issue(make_req(MODE_FUNC, 1, 16'h0, 8'(8'hFF - g), g, 0));
      end
      issue(make_req(MODE_SPEED, 31, 16'h0000, 8'h00, 0, 0));
      issue(make_req(MODE_ESTOP, 0, 16'h0000, 8'h00, 0, 0));
      issue(make_req(MODE_PURGE, 31, 16'h0000, 8'h00, 0, 0));
      for (int k = 0; k < 20; k++) issue(make_req(MODE_NEXT, 0, 16'h0, 8'h0, 0, 0));

      while (items < 400) begin
         if (items >= 330) quiet = 1;
         if (items >= 100 && items < 103) begin
            for (int k = 0; k < 34; k++) begin
               issue(make_req(MODE_ADD, 0, 16'(16'h0100 + k), 8'h00, 0, 0));
            end
            for (int k = 8; k < 32; k++) issue(make_req(MODE_PURGE, k, 16'h0, 8'h0, 0, 0));
         end else if (items >= 150 && items < 153) begin
            hold_cycles = 400;
            repeat (30) issue(rand_req());
         end else if (items >= 200 && items < 203) begin
            @(negedge clock);
            req_valid = 0;
            wait (sb.pending.size() == 0);
            issue(rand_req());
         end else if (items >= 250 && items < 253) begin
            h = sb.any_valid();
            if (h < 0) begin
               issue(make_req(MODE_ADD, 0, 16'h0042, 8'h00, 0, 0));
               h = sb.any_valid();
            end
            for (int k = 0; k < 18; k++) begin
               issue(make_req(MODE_SPEED, h, 16'h0, 8'($urandom), 0, 0));
            end
         end else begin
            issue(rand_req());
         end
      end

      @(negedge clock);
      req_valid = 0;
      wait (sb.pending.size() == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d requests and checked %0d results, including full table,",
               items, sb.checked);
      $display("full one-shot queue, emergency stop and long output back-pressure.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing.", sb.mismatches, sb.pending.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
